>>> rtl/sorted_distinct_marker_histogram_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted distinct marker histogram
// Implication checks, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef SORTED_DISTINCT_MARKER_HISTOGRAM_ASSERT_SVH
`define SORTED_DISTINCT_MARKER_HISTOGRAM_ASSERT_SVH

// ante implies cons in the same cycle
`define SDMH_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdmh assertion failed");

// ante implies cons in the next cycle
`define SDMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdmh assertion failed");

`endif

>>> rtl/sdmh_pkg.sv
// ----------------------------------------------------------------------------
// sdmh_pkg
// Shared constants, entry and control types for the marker histogram chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdmh_pkg;

  localparam int MAX_DISTINCT    = 16;
  localparam int COUNT_WIDTH     = 24;
  localparam int KEY_WIDTH       = 32;
  localparam int OUT_COUNT_WIDTH = 24;

  typedef struct packed {
    logic                   valid;
    logic [KEY_WIDTH-1:0]   key;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ABSORB,
    CELL_SHIFT_OUT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t           mode;
    logic [KEY_WIDTH-1:0] key;
    logic                 match_any;
    logic                 ins_en;
  } cell_ctrl_t;

  // signed order on two's complement patterns
  function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

>>> rtl/sdmh_cell.sv
// ----------------------------------------------------------------------------
// sdmh_cell
// One slot of the sorted chain: match/compare, count, insert shift, drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdmh_cell (
  input  logic                clk,
  input  logic                rst,
  input  sdmh_pkg::cell_ctrl_t ctrl,
  input  sdmh_pkg::entry_t    left_entry,
  input  logic                left_gt,
  input  sdmh_pkg::entry_t    right_entry,
  output sdmh_pkg::entry_t    entry,
  output logic                match,
  output logic                gt
);
  import sdmh_pkg::*;

  entry_t entry_next;

  assign match = entry.valid && (entry.key == ctrl.key);
  // new key sorts before this slot (empty slots count as greater)
  assign gt    = !entry.valid || key_less(ctrl.key, entry.key);

  always_comb begin
    entry_next = entry;
    case (ctrl.mode)
      CELL_ABSORB: begin
        if (ctrl.match_any) begin
          if (match && (entry.count != {COUNT_WIDTH{1'b1}})) begin
            entry_next.count = entry.count + COUNT_WIDTH'(1);
          end
        end else if (ctrl.ins_en) begin
          if (left_gt) begin
            entry_next = left_entry;
          end else if (gt) begin
            entry_next.valid = 1'b1;
            entry_next.key   = ctrl.key;
            entry_next.count = COUNT_WIDTH'(1);
          end
        end
      end
      CELL_SHIFT_OUT: entry_next = right_entry;
      default: entry_next = entry;
    endcase
  end

  // only the valid bit is reset; key and count are don't-care while invalid
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.key   <= entry_next.key;
    entry.count <= entry_next.count;
  end

endmodule

>>> rtl/sorted_distinct_marker_histogram.sv
// ----------------------------------------------------------------------------
// sorted_distinct_marker_histogram
// Counts distinct signed face markers and emits them sorted on end of set.
// ----------------------------------------------------------------------------
// Channel   Handshake          Fields
// input     start & !busy      face_marker, end_of_set
// result    strobe (1 cycle)   marker_value, face_count, last_of_run,
//                              table_overflowed
//
// A marker without end_of_set is counted when accepted; busy stays low.
// An end_of_set item is counted first, then the chain shifts out through
// cell 0, one distinct marker per cycle (busy high meanwhile).
// Each result shows on the ports in the cycle after its drain cycle.
// rst clears the chain valid bits, the overflow flag and the drain state.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_distinct_marker_histogram (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sdmh_pkg::KEY_WIDTH-1:0] face_marker,
  input  logic                                 end_of_set,
  output logic                                 strobe,
  output logic signed [sdmh_pkg::KEY_WIDTH-1:0] marker_value,
  output logic [sdmh_pkg::OUT_COUNT_WIDTH-1:0] face_count,
  output logic                                 last_of_run,
  output logic                                 table_overflowed
);
  import sdmh_pkg::*;
  `include "sorted_distinct_marker_histogram_assert.svh"

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  localparam logic [31:0] OUT_MAX = 32'((64'd1 << OUT_COUNT_WIDTH) - 64'd1);

  state_t state;
  logic   overflow_seen;
  logic   accept;

  cell_ctrl_t ctrl;
  entry_t     entries [MAX_DISTINCT];
  logic       match   [MAX_DISTINCT];
  logic       gt      [MAX_DISTINCT];
  logic [MAX_DISTINCT-1:0] match_vec;

  logic        table_full;
  logic        drain_last;
  logic [31:0] head_count;

  assign busy   = (state == S_DRAIN);
  assign accept = start && !busy;

  always_comb begin
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      match_vec[i] = match[i];
    end
  end

  // sorted chain keeps valid entries packed toward cell 0
  assign table_full = entries[MAX_DISTINCT-1].valid;
  assign drain_last = !entries[1].valid;

  always_comb begin
    ctrl.key       = face_marker;
    ctrl.match_any = |match_vec;
    // insert only when no match and a free slot remains; otherwise drop
    ctrl.ins_en    = !(|match_vec) && !table_full;
    if (accept) begin
      ctrl.mode = CELL_ABSORB;
    end else if (busy) begin
      ctrl.mode = CELL_SHIFT_OUT;
    end else begin
      ctrl.mode = CELL_HOLD;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_DISTINCT; g++) begin : g_cell
      entry_t left_e;
      logic   left_g;
      entry_t right_e;
      if (g == 0) begin : g_first
        assign left_e = '0;
        assign left_g = 1'b0;
      end else begin : g_mid_l
        assign left_e = entries[g-1];
        assign left_g = gt[g-1];
      end
      if (g == MAX_DISTINCT - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_mid_r
        assign right_e = entries[g+1];
      end
      sdmh_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_entry  (left_e),
        .left_gt     (left_g),
        .right_entry (right_e),
        .entry       (entries[g]),
        .match       (match[g]),
        .gt          (gt[g])
      );
    end
  endgenerate

  // head cell count widened to 32 bits for the clamp to the output field width
  assign head_count = 32'(entries[0].count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      overflow_seen <= 1'b0;
      strobe        <= 1'b0;
      last_of_run   <= 1'b0;
    end else begin
      strobe      <= 1'b0;
      last_of_run <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!(|match_vec) && table_full) begin
              overflow_seen <= 1'b1;
            end
            if (end_of_set) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          strobe      <= 1'b1;
          last_of_run <= drain_last;
          // payload of the head cell, no reset needed
          marker_value     <= entries[0].key;
          face_count       <= (head_count > OUT_MAX) ? OUT_COUNT_WIDTH'(OUT_MAX)
                                                     : head_count[OUT_COUNT_WIDTH-1:0];
          table_overflowed <= overflow_seen;
          if (drain_last) begin
            state         <= S_IDLE;
            overflow_seen <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SDMH_ASSERT_SAME(a_last_has_strobe, clk, rst, last_of_run, strobe)
  `SDMH_ASSERT_NEXT(a_end_starts_drain, clk, rst, accept && end_of_set, busy)
  `SDMH_ASSERT_NEXT(a_run_continues, clk, rst, strobe && !last_of_run, strobe)
  `SDMH_ASSERT_SAME(a_drain_head_valid, clk, rst, busy, entries[0].valid)

endmodule
